// ----- rtl/vod_pkg.sv -----
// Shared types and constants for the octal escape decoder.
`default_nettype none

package vod_pkg;

   localparam logic [7:0] Backslash  = 8'h5C;
   localparam logic [7:0] DigitZero  = 8'h30;
   localparam logic [7:0] DigitSeven = 8'h37;

   // Escape progress codes: what is held from an escape in progress.
   localparam logic [1:0] HeldNone  = 2'd0;
   localparam logic [1:0] HeldSlash = 2'd1;
   localparam logic [1:0] HeldOne   = 2'd2;
   localparam logic [1:0] HeldTwo   = 2'd3;

   localparam int MaxBytes   = 4;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // One queued command: a group of decoded bytes that a single input byte produced.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               count;
      logic                     last;
   } vod_cmd_type;

   function automatic logic [7:0] digit_char(input logic [2:0] d);
      digit_char = DigitZero + {5'b0, d};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/vod_front.sv -----
// Front end: tracks escape progress and turns each input byte into a byte group.
`default_nettype none

module vod_front
   import vod_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        q_full,
   output logic             q_push,
   output vod_cmd_type      q_cmd,
   output logic [1:0]       held
);

   logic [1:0] held_ff, held_in;
   logic [2:0] first_ff, first_in;
   logic [2:0] second_ff, second_in;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign held       = held_ff;

   always_comb begin
      logic       is_digit;
      logic       consumed;
      logic [2:0] n;
      logic [1:0] nh;
      logic [2:0] nf;
      logic [2:0] ns;

      is_digit = (req_tdata >= DigitZero) && (req_tdata <= DigitSeven);
      consumed = (held_ff != HeldNone) && is_digit;
      n        = 3'd0;
      nh       = HeldNone;
      nf       = first_ff;
      ns       = second_ff;
      q_cmd    = '0;

      // A broken escape releases the backslash and its digits as literals.
      if (held_ff != HeldNone && !is_digit) begin
         q_cmd.bytes[0] = Backslash;
         q_cmd.bytes[1] = digit_char(first_ff);
         q_cmd.bytes[2] = digit_char(second_ff);
         n              = {1'b0, held_ff};
      end

      if (consumed) begin
         unique case (held_ff)
            HeldSlash: begin
               nf = req_tdata[2:0];
               nh = HeldOne;
            end
            HeldOne: begin
               ns = req_tdata[2:0];
               nh = HeldTwo;
            end
            default: begin
               q_cmd.bytes[0] = {first_ff[1:0], second_ff, req_tdata[2:0]};
               n              = 3'd1;
               nh             = HeldNone;
            end
         endcase
      end else if (req_tdata == Backslash) begin
         nh = HeldSlash;
      end else begin
         q_cmd.bytes[n[1:0]] = req_tdata;
         n                   = n + 3'd1;
      end

      // At string end whatever is still held goes out literally.
      if (req_tlast) begin
         if (nh != HeldNone) begin
            q_cmd.bytes[n[1:0]] = Backslash;
            n                   = n + 3'd1;
         end
         if (nh == HeldOne || nh == HeldTwo) begin
            q_cmd.bytes[n[1:0]] = digit_char(nf);
            n                   = n + 3'd1;
         end
         if (nh == HeldTwo) begin
            q_cmd.bytes[n[1:0]] = digit_char(ns);
            n                   = n + 3'd1;
         end
         nh = HeldNone;
         nf = 3'd0;
         ns = 3'd0;
      end

      q_cmd.count = n;
      q_cmd.last  = req_tlast;
      held_in     = nh;
      first_in    = nf;
      second_in   = ns;
   end

   assign q_push = accept && (q_cmd.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= HeldNone;
         first_ff  <= 3'd0;
         second_ff <= 3'd0;
      end else if (accept) begin
         held_ff   <= held_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vod_queue.sv -----
// Short command queue between the front end and the output sequencer.
`default_nettype none

module vod_queue
   import vod_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  vod_cmd_type           push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output vod_cmd_type           pop_cmd,
   output logic [QueueCntW-1:0]  level
);

   vod_cmd_type                 slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]        wr_ff, rd_ff;
   logic [QueueCntW-1:0]        cnt_ff;

   assign full      = (cnt_ff == QueueCntW'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign pop_cmd   = slot_ff[rd_ff];
   assign level     = cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QueuePtrW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QueuePtrW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QueueCntW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QueueCntW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vod_back.sv -----
// Back end: plays out the bytes of each queued group, one per transfer.
`default_nettype none

module vod_back
   import vod_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  vod_cmd_type      q_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   vod_cmd_type cmd_ff;
   logic [1:0]  idx_ff;
   logic        valid_ff;
   logic        final_beat;
   logic        done;

   assign final_beat = ({1'b0, idx_ff} == (cmd_ff.count - 3'd1));
   assign done       = valid_ff && rsp_tready && final_beat;
   assign q_pop      = q_valid && (!valid_ff || done);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = cmd_ff.bytes[idx_ff];
   assign rsp_tlast  = cmd_ff.last && final_beat;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (done) begin
         valid_ff <= 1'b0;
      end else if (valid_ff && rsp_tready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vis_octal_escape_decoder.sv -----
// Top level of the streaming octal escape decoder.
//
// req_*: one encoded byte per transfer, req_tlast on the final byte of a string.
// rsp_*: one decoded byte per transfer, rsp_tlast on the final decoded byte.
// A backslash and three octal digits become one byte (low 8 bits of the value);
// broken escapes come out literally and pending bytes are flushed at string end.
//
// The front end classifies each accepted byte into a group of zero to four
// output bytes and pushes it into a four-entry queue in the same cycle. The
// back end loads a group from the queue into its own register and offers its
// bytes on rsp_* from there. Both sides sustain one byte per cycle when not
// stalled; the back end plays a group out at one byte per cycle, so a byte
// that expands into several outputs fills the queue, and req_tready drops
// only when it is full. When the receiver stalls, rsp_* hold and the queue
// absorbs up to four groups before input stalls too. Synchronous reset
// empties the queue, drops rsp_tvalid and forgets any escape in progress.
`default_nettype none

module vis_octal_escape_decoder
   import vod_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast
);

   vod_cmd_type            push_cmd;
   vod_cmd_type            pop_cmd;
   logic                   push;
   logic                   pop;
   logic                   full;
   logic                   not_empty;
   logic [QueueCntW-1:0]   level;
   logic [1:0]             held;

   vod_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (full),
      .q_push     (push),
      .q_cmd      (push_cmd),
      .held       (held)
   );

   vod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_cmd   (pop_cmd),
      .level     (level)
   );

   vod_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (not_empty),
      .q_cmd      (pop_cmd),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A string end always leaves nothing pending.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> held == HeldNone)
      else $error("escape state not cleared after string end");

   // Only non-empty groups of at most four bytes enter the queue.
   a_group_size: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_cmd.count != 3'd0) && (push_cmd.count <= 3'd4))
      else $error("queued byte group has an illegal size");

   // A string end always yields a byte, so its group is queued.
   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |-> push)
      else $error("string end produced no queued group");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= QueueCntW'(QueueDepth))
      else $error("queue level beyond its depth");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the streaming octal escape decoder.
`timescale 1ns / 1ps

module tb_top
   import vod_pkg::*;
();

   localparam int ClockPeriod    = 4;
   localparam int ResetCycles    = 7;
   localparam int LongHoldCycles = 80;
   localparam int DrainCycles    = 10;
   localparam int LimitCycles    = 200000;
   localparam int MaxReports     = 25;

   typedef struct {
      logic [7:0] data;
      logic       tlast;
   } decoded_byte_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;

   // Expected decoded bytes, oldest first.
   decoded_byte_type pending_decoded[$];
   decoded_byte_type head_byte;
   logic [7:0]       text_buf[$];

   // Predictor state: escape progress and the digits held so far.
   logic [1:0] held_state = HeldNone;
   logic [2:0] first_oct  = 3'd0;
   logic [2:0] second_oct = 3'd0;

   int unsigned error_count     = 0;
   int unsigned bytes_sent      = 0;
   int unsigned strings_sent    = 0;
   int unsigned bytes_checked   = 0;
   int unsigned escapes_decoded = 0;
   int unsigned cycle_count     = 0;

   // Idle controls and the receiver's hold-off request.
   logic        send_idle = 1'b0;
   logic        recv_idle = 1'b0;
   int unsigned hold_gen  = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;

   vis_octal_escape_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LimitCycles) begin
         $display("Timed out after %0d cycles with %0d decoded bytes outstanding.",
                  cycle_count, pending_decoded.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MaxReports)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   task automatic push_decoded(input logic [7:0] value, inout int unsigned made);
      pending_decoded.push_back('{data: value, tlast: 1'b0});
      made++;
   endtask

   // Works out the decoded bytes that one accepted input byte releases.
   task automatic decode_step(input logic [7:0] b, input logic is_final);
      logic        is_digit;
      logic        taken;
      int unsigned made;
      is_digit = (b >= DigitZero) && (b <= DigitSeven);
      taken = 1'b0;
      made = 0;
      unique case (held_state)
         HeldSlash: begin
            if (is_digit) begin
               first_oct  = b[2:0];
               held_state = HeldOne;
               taken      = 1'b1;
            end else begin
               push_decoded(Backslash, made);
               held_state = HeldNone;
            end
         end
         HeldOne: begin
            if (is_digit) begin
               second_oct = b[2:0];
               held_state = HeldTwo;
               taken      = 1'b1;
            end else begin
               push_decoded(Backslash, made);
               push_decoded(DigitZero | {5'b0, first_oct}, made);
               held_state = HeldNone;
            end
         end
         HeldTwo: begin
            if (is_digit) begin
               // The top bit of the first digit falls off the byte.
               push_decoded({first_oct[1:0], second_oct, b[2:0]}, made);
               escapes_decoded++;
               taken = 1'b1;
            end else begin
               push_decoded(Backslash, made);
               push_decoded(DigitZero | {5'b0, first_oct}, made);
               push_decoded(DigitZero | {5'b0, second_oct}, made);
            end
            held_state = HeldNone;
         end
         default: held_state = HeldNone;
      endcase

      // A byte that broke an escape is looked at again from scratch.
      if (!taken) begin
         if (b == Backslash)
            held_state = HeldSlash;
         else
            push_decoded(b, made);
      end

      if (is_final) begin
         if (held_state >= HeldSlash)
            push_decoded(Backslash, made);
         if (held_state >= HeldOne)
            push_decoded(DigitZero | {5'b0, first_oct}, made);
         if (held_state >= HeldTwo)
            push_decoded(DigitZero | {5'b0, second_oct}, made);
         held_state = HeldNone;
         first_oct  = 3'd0;
         second_oct = 3'd0;
         if (made > 0)
            pending_decoded[pending_decoded.size() - 1].tlast = 1'b1;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input logic is_final);
      int unsigned gap;
      if (send_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_final;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_step(b, is_final);
      bytes_sent++;
      if (is_final)
         strings_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] random_digit();
      return DigitZero + 8'($urandom_range(0, 7));
   endfunction

   // Mostly whole escapes and plain bytes, with broken and dangling escapes mixed in.
   task automatic build_string();
      int unsigned tokens;
      int unsigned kind;
      int unsigned ndig;
      logic [7:0]  breaker;
      text_buf.delete();
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            text_buf.push_back(Backslash);
            repeat (3) text_buf.push_back(random_digit());
         end else if (kind < 75) begin
            text_buf.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 92) begin
            text_buf.push_back(Backslash);
            ndig = $urandom_range(0, 2);
            repeat (ndig) text_buf.push_back(random_digit());
            if ($urandom_range(0, 3) == 0) begin
               breaker = Backslash;
            end else begin
               breaker = 8'($urandom_range(0, 255));
               while (breaker >= DigitZero && breaker <= DigitSeven)
                  breaker = 8'($urandom_range(0, 255));
            end
            text_buf.push_back(breaker);
         end else begin
            text_buf.push_back(Backslash);
         end
      end
   endtask

   task automatic send_strings(input int unsigned n_bytes);
      int unsigned sent_here;
      sent_here = 0;
      while (sent_here < n_bytes) begin
         build_string();
         for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
         sent_here += text_buf.size();
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_decoded.size() != 0) @(negedge clock);
   endtask

   // Byte extremes, bytes just outside the digit range, whole escapes, and escapes broken or left dangling.
   task automatic test_directed();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_text("\\777");
      send_text("\\000");
      send_text("\\1/");
      send_text("\\128");
      send_text("\\12\\3");
      send_text("\\");
      send_text("\\\\");
   endtask

   task automatic test_random_strings();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_strings(200);
   endtask

   // The receiver holds off long enough for the queue to fill and stall the input.
   task automatic test_receiver_hold();
      send_idle = 1'b0;
      // The last byte was already transferred, so it must not stay offered.
      req_tvalid <= 1'b0;
      @(posedge clock);
      hold_gen++;
      @(negedge clock);
      send_strings(40);
   endtask

   task automatic test_drain_pauses();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (3) begin
         send_strings(10);
         wait_drained();
      end
   endtask

   task automatic test_full_rate();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_strings(70);
   endtask

   always @(negedge clock) begin
      if (hold_gen != hold_seen) begin
         hold_seen = hold_gen;
         hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_decoded.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            head_byte = pending_decoded.pop_front();
            if (rsp_tdata !== head_byte.data)
               report_mismatch($sformatf("byte %0d: got %02h, want %02h",
                                         bytes_checked, rsp_tdata, head_byte.data));
            if (rsp_tlast !== head_byte.tlast)
               report_mismatch($sformatf("byte %0d: tlast %0b, want %0b",
                                         bytes_checked, rsp_tlast, head_byte.tlast));
            bytes_checked++;
         end
      end
   end

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_strings();
      test_receiver_hold();
      test_drain_pauses();
      test_full_rate();

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (pending_decoded.size() != 0)
         report_mismatch($sformatf("%0d decoded bytes never arrived", pending_decoded.size()));

      $display("Sent %0d encoded bytes in %0d strings; checked %0d decoded bytes, %0d from escapes.",
               bytes_sent, strings_sent, bytes_checked, escapes_decoded);
      $display("Included a %0d-cycle receiver hold-off, drain pauses and a full-rate stretch.",
               LongHoldCycles);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/vod_pkg.sv
rtl/vod_front.sv
rtl/vod_queue.sv
rtl/vod_back.sv
rtl/vis_octal_escape_decoder.sv
dv/tb_top.sv
